/* hw/rtl/fdg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and per-format constants of the F/D/G arithmetic unit.
// Depends on nothing; every other file imports it.
package fdg_pkg;

   localparam int OPND_W = 64;
   localparam int EXP_W  = 11;
   localparam int WEXP_W = 14;
   localparam int CNT_W  = 6;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] FMT_F = 2'd0;
   localparam logic [1:0] FMT_D = 2'd1;
   localparam logic [1:0] FMT_G = 2'd2;

   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_RSVD = 3'd1;
   localparam logic [2:0] ST_OVFL = 3'd2;
   localparam logic [2:0] ST_UNFL = 3'd3;
   localparam logic [2:0] ST_DZRO = 3'd4;

   typedef struct packed {
      logic               sign;
      logic [EXP_W-1:0]   exp;
      logic [OPND_W-1:0]  frac;
   } unp_type;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_LOAD    = 12'b0000_0000_0010,
      S_ALIGN   = 12'b0000_0000_0100,
      S_SUM     = 12'b0000_0000_1000,
      S_MUL_PP  = 12'b0000_0001_0000,
      S_MUL_ACC = 12'b0000_0010_0000,
      S_MUL_FIN = 12'b0000_0100_0000,
      S_DIV     = 12'b0000_1000_0000,
      S_DIV_FIN = 12'b0001_0000_0000,
      S_NORM    = 12'b0010_0000_0000,
      S_ROUND   = 12'b0100_0000_0000,
      S_EMIT    = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic align;
      logic sum;
      logic mul_pp;
      logic mul_acc;
      logic mul_fin;
      logic div_step;
      logic div_fin;
      logic norm;
      logic round;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic       load_err;
      logic [1:0] op;
      logic       mul_last;
      logic       div_more;
      logic       norm_done;
   } sts_type;

   function automatic logic [EXP_W-1:0] fmt_exp_max(logic [1:0] f);
      logic [EXP_W-1:0] r;
      unique case (f)
         FMT_G:   r = 11'h7FF;
         default: r = 11'h0FF;
      endcase
      return r;
   endfunction

   function automatic logic [EXP_W-1:0] fmt_bias(logic [1:0] f);
      logic [EXP_W-1:0] r;
      unique case (f)
         FMT_G:   r = 11'd1024;
         default: r = 11'd128;
      endcase
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] fmt_steps(logic [1:0] f);
      logic [CNT_W-1:0] r;
      unique case (f)
         FMT_F:   r = 6'd27;
         FMT_D:   r = 6'd59;
         default: r = 6'd56;
      endcase
      return r;
   endfunction

   function automatic logic [OPND_W-1:0] fmt_round(logic [1:0] f);
      logic [OPND_W-1:0] r;
      unique case (f)
         FMT_F:   r = 64'h0000_0080_0000_0000;
         FMT_D:   r = 64'h0000_0000_0000_0080;
         default: r = 64'h0000_0000_0000_0400;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/fdg_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on fdg_pkg for the field widths.
interface fdg_req_if import fdg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [1:0]        fmt;
   logic [OPND_W-1:0] operand_a;
   logic [OPND_W-1:0] operand_b;
   modport source (output valid, opcode, fmt, operand_a, operand_b, input ready);
   modport sink   (input valid, opcode, fmt, operand_a, operand_b, output ready);
endinterface

interface fdg_rsp_if import fdg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OPND_W-1:0] result_value;
   logic [2:0]        status;
   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

/* hw/rtl/float_fdg_arith_unit.sv */
`timescale 1ns / 1ps
// One word at a time; the divide loop produces one quotient bit per cycle.
// A finished result waits in the output register while the next request is accepted.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
//
// Top level of the F/D/G floating add, subtract, multiply and divide unit.
// Depends on fdg_pkg, the channel interfaces, fdg_ctrl and fdg_dp.
module float_fdg_arith_unit import fdg_pkg::*; (
   input logic         clock,
   input logic         reset,
   fdg_req_if.sink     req_chan,
   fdg_rsp_if.source   rsp_chan
);

   // The sequencer owns the handshakes and the state; the datapath holds
   // the request word, the working sign/exponent/fraction and the result.
   cmd_type cmd;
   sts_type sts;

   fdg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Subtract gives b minus a and divide gives b over a; the datapath flips
   // the sign of a for subtract and treats b as the dividend.
   fdg_dp u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_chan.opcode),
      .req_fmt          (req_chan.fmt),
      .req_operand_a    (req_chan.operand_a),
      .req_operand_b    (req_chan.operand_b),
      .rsp_result_value (rsp_chan.result_value),
      .rsp_status       (rsp_chan.status)
   );

endmodule

/* hw/rtl/fdg_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the F/D/G unit: steps the datapath through each operation.
// Depends on fdg_pkg for the state, command and status types.
module fdg_ctrl import fdg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            if (sts.load_err) state_in = S_EMIT;
            else begin
               unique case (sts.op)
                  OP_MUL:  state_in = S_MUL_PP;
                  OP_DIV:  state_in = S_DIV;
                  default: state_in = S_ALIGN;
               endcase
            end
         end
         S_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_NORM;
         end
         S_MUL_PP: begin
            cmd.mul_pp = 1'b1;
            state_in   = S_MUL_ACC;
         end
         S_MUL_ACC: begin
            cmd.mul_acc = 1'b1;
            state_in    = sts.mul_last ? S_MUL_FIN : S_MUL_PP;
         end
         S_MUL_FIN: begin
            cmd.mul_fin = 1'b1;
            state_in    = S_NORM;
         end
         S_DIV: begin
            cmd.div_step = sts.div_more;
            if (!sts.div_more) state_in = S_DIV_FIN;
         end
         S_DIV_FIN: begin
            cmd.div_fin = 1'b1;
            state_in    = S_NORM;
         end
         S_NORM: begin
            cmd.norm = !sts.norm_done;
            if (sts.norm_done) state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = out_free;
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/fdg_dp.sv */
`timescale 1ns / 1ps
// Datapath of the F/D/G unit: unpack, align/add, multiply, divide,
// normalize, round and pack. Depends on fdg_pkg; driven by fdg_ctrl.
module fdg_dp import fdg_pkg::*; (
   input  logic              clock,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [1:0]        req_opcode,
   input  logic [1:0]        req_fmt,
   input  logic [OPND_W-1:0] req_operand_a,
   input  logic [OPND_W-1:0] req_operand_b,
   output logic [OPND_W-1:0] rsp_result_value,
   output logic [2:0]        rsp_status
);

   function automatic unp_type unpack(logic [OPND_W-1:0] v, logic [1:0] f);
      unp_type     u;
      logic [31:0] lw0;
      logic [31:0] lw1;
      lw0    = v[31:0];
      lw1    = v[63:32];
      u.sign = lw0[15];
      if (f == FMT_G) u.exp = lw0[14:4];
      else            u.exp = {3'b000, lw0[14:7]};
      if (u.exp == '0) u.frac = '0;
      else begin
         unique case (f)
            FMT_F:   u.frac = {1'b1, lw0[6:0], lw0[31:16], 40'b0};
            FMT_D:   u.frac = {1'b1, lw0[6:0], lw0[31:16], lw1[15:0], lw1[31:16], 8'b0};
            default: u.frac = {1'b1, lw0[3:0], lw0[31:16], lw1[15:0], lw1[31:16], 11'b0};
         endcase
      end
      return u;
   endfunction

   // Captured request word.
   logic [1:0]        op_ff, fmt_ff;
   logic [OPND_W-1:0] opa_ff, opb_ff;
   // Unpacked operands and load status.
   unp_type           a_ff, b_ff;
   logic [2:0]        err_ff;
   // Working value.
   logic                     sign_ff;
   logic signed [WEXP_W-1:0] exp_ff;
   logic [OPND_W-1:0]        frac_ff;
   // Add/subtract alignment.
   logic [OPND_W-1:0] small_ff;
   logic [EXP_W-1:0]  dist_ff;
   logic              eff_sub_ff;
   // Multiply.
   logic [1:0]          mul_idx_ff;
   logic [OPND_W-1:0]   pp_ff;
   logic [2*OPND_W-1:0] acc_ff;
   // Divide.
   logic [OPND_W-1:0] rem_ff, dvr_ff, quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   // Result word.
   logic [OPND_W-1:0] res_ff;
   logic [2:0]        stat_ff;

   unp_type                  ua, ub;
   logic [2:0]               load_st;
   logic                     x_zero, y_zero, do_swap;
   unp_type                  big, sml;
   logic [5:0]               sh;
   logic [OPND_W-1:0]        al, sum_frac;
   logic [OPND_W:0]          add_full;
   logic [31:0]              mul_x, mul_y;
   logic [2*OPND_W-1:0]      acc_add;
   logic                     rem_ge;
   logic [OPND_W-1:0]        rem_sub;
   logic [6:0]               qsh_full;
   logic [OPND_W-1:0]        rnd;
   logic signed [WEXP_W-1:0] max_s, bias_s;
   logic [31:0]              lw0, lw1;
   logic [OPND_W-1:0]        pack_val;
   logic [2:0]               pack_st;

   assign ua = unpack(opa_ff, fmt_ff);
   assign ub = unpack(opb_ff, fmt_ff);

   always_comb begin
      priority if (fmt_ff == 2'd3)                 load_st = ST_RSVD;
      else if (ua.exp == '0 && ua.sign)            load_st = ST_RSVD;
      else if (ub.exp == '0 && ub.sign)            load_st = ST_RSVD;
      else if (op_ff == OP_DIV && ua.exp == '0)    load_st = ST_DZRO;
      else                                         load_st = ST_OK;
   end

   assign max_s  = $signed({3'b000, fmt_exp_max(fmt_ff)});
   assign bias_s = $signed({3'b000, fmt_bias(fmt_ff)});

   // Order the operands by magnitude; a zero operand ends up small unless both are zero.
   always_comb begin
      x_zero  = (a_ff.exp == '0);
      y_zero  = (b_ff.exp == '0);
      do_swap = x_zero || (!y_zero && (a_ff.exp < b_ff.exp ||
                (a_ff.exp == b_ff.exp && a_ff.frac < b_ff.frac)));
      big     = do_swap ? b_ff : a_ff;
      sml     = do_swap ? a_ff : b_ff;
   end

   // Alignment: an effective subtract shifts the negated small fraction
   // with ones filled in from the top.
   always_comb begin
      sh = dist_ff[5:0];
      if (eff_sub_ff) begin
         if (dist_ff >= 11'd64) al = '1;
         else al = ((64'd0 - small_ff) >> sh) | ~({OPND_W{1'b1}} >> sh);
      end else begin
         if (dist_ff >= 11'd64) al = '0;
         else al = small_ff >> sh;
      end
      add_full = {1'b0, frac_ff} + {1'b0, al};
      if (eff_sub_ff && dist_ff == '0) sum_frac = frac_ff - small_ff;
      else                             sum_frac = add_full[OPND_W-1:0];
   end

   always_comb begin
      unique case (mul_idx_ff)
         2'd0: begin mul_x = a_ff.frac[63:32]; mul_y = b_ff.frac[63:32]; end
         2'd1: begin mul_x = a_ff.frac[31:0];  mul_y = b_ff.frac[31:0];  end
         2'd2: begin mul_x = a_ff.frac[63:32]; mul_y = b_ff.frac[31:0];  end
         default: begin mul_x = a_ff.frac[31:0]; mul_y = b_ff.frac[63:32]; end
      endcase
      unique case (mul_idx_ff)
         2'd0:    acc_add = {pp_ff, 64'd0};
         2'd1:    acc_add = {64'd0, pp_ff};
         default: acc_add = {32'd0, pp_ff, 32'd0};
      endcase
   end

   assign rem_ge   = (rem_ff >= dvr_ff);
   assign rem_sub  = rem_ge ? rem_ff - dvr_ff : rem_ff;
   assign qsh_full = 7'd64 - {1'b0, cnt_ff};
   assign rnd      = frac_ff + fmt_round(fmt_ff);

   // Range check and field packing of the rounded value.
   always_comb begin
      unique case (fmt_ff)
         FMT_G: begin
            lw0 = {frac_ff[58:43], sign_ff, exp_ff[10:0], frac_ff[62:59]};
            lw1 = {frac_ff[26:11], frac_ff[42:27]};
         end
         default: begin
            lw0 = {frac_ff[55:40], sign_ff, exp_ff[7:0], frac_ff[62:56]};
            lw1 = {frac_ff[23:8], frac_ff[39:24]};
         end
      endcase
      pack_val = '0;
      priority if (err_ff != ST_OK) pack_st = err_ff;
      else if (frac_ff == '0)       pack_st = ST_OK;
      else if (exp_ff > max_s)      pack_st = ST_OVFL;
      else if (exp_ff <= 0)         pack_st = ST_UNFL;
      else begin
         pack_st  = ST_OK;
         pack_val = (fmt_ff == FMT_F) ? {32'd0, lw0} : {lw1, lw0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         fmt_ff <= req_fmt;
         opa_ff <= req_operand_a;
         opb_ff <= req_operand_b;
      end
      if (cmd.load) begin
         a_ff        <= '{sign: ua.sign ^ (op_ff == OP_SUB), exp: ua.exp, frac: ua.frac};
         b_ff        <= ub;
         err_ff      <= load_st;
         mul_idx_ff  <= '0;
         acc_ff      <= '0;
         rem_ff      <= ub.frac >> 1;
         dvr_ff      <= ua.frac >> 1;
         quo_ff      <= '0;
         cnt_ff      <= '0;
      end
      if (cmd.align) begin
         sign_ff    <= big.sign;
         exp_ff     <= $signed({3'b000, big.exp});
         frac_ff    <= big.frac;
         small_ff   <= sml.frac;
         dist_ff    <= big.exp - sml.exp;
         eff_sub_ff <= (a_ff.sign ^ b_ff.sign) && !x_zero && !y_zero;
      end
      if (cmd.sum) begin
         if (!eff_sub_ff && add_full[OPND_W]) begin
            frac_ff <= {1'b1, add_full[OPND_W-1:1]};
            exp_ff  <= exp_ff + 14'sd1;
         end else begin
            frac_ff <= sum_frac;
         end
      end
      if (cmd.mul_pp) pp_ff <= mul_x * mul_y;
      if (cmd.mul_acc) begin
         acc_ff     <= acc_ff + acc_add;
         mul_idx_ff <= mul_idx_ff + 2'd1;
      end
      if (cmd.mul_fin) begin
         sign_ff <= a_ff.sign ^ b_ff.sign;
         exp_ff  <= $signed({3'b000, a_ff.exp}) + $signed({3'b000, b_ff.exp}) - bias_s;
         frac_ff <= acc_ff[2*OPND_W-1:OPND_W];
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[OPND_W-2:0], rem_ge};
         rem_ff <= {rem_sub[OPND_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.div_fin) begin
         sign_ff <= a_ff.sign ^ b_ff.sign;
         exp_ff  <= $signed({3'b000, b_ff.exp}) - $signed({3'b000, a_ff.exp})
                    + bias_s + 14'sd1;
         frac_ff <= (cnt_ff == '0) ? '0 : quo_ff << qsh_full[5:0];
      end
      if (cmd.norm) begin
         frac_ff <= {frac_ff[OPND_W-2:0], 1'b0};
         exp_ff  <= exp_ff - 14'sd1;
      end
      if (cmd.round && frac_ff != '0) begin
         if (!rnd[OPND_W-1]) begin
            frac_ff <= rnd >> 1;
            exp_ff  <= exp_ff + 14'sd1;
         end else begin
            frac_ff <= rnd;
         end
      end
      if (cmd.emit) begin
         res_ff  <= pack_val;
         stat_ff <= pack_st;
      end
   end

   assign sts.load_err  = (load_st != ST_OK);
   assign sts.op        = op_ff;
   assign sts.mul_last  = (fmt_ff == FMT_F) ? (mul_idx_ff == 2'd0) : (mul_idx_ff == 2'd3);
   assign sts.div_more  = (cnt_ff < fmt_steps(fmt_ff)) && (rem_ff != '0);
   assign sts.norm_done = (frac_ff == '0) || frac_ff[OPND_W-1];

   assign rsp_result_value = res_ff;
   assign rsp_status       = stat_ff;

endmodule

/* hw/rtl/fdg_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the F/D/G unit, bound to its top level.
// Depends on fdg_pkg for the status codes.
module fdg_checker import fdg_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [OPND_W-1:0] rsp_result_value,
   input logic [2:0]        rsp_status
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) && $stable(rsp_status))
      else $error("stalled response changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_value == '0)
      else $error("error response carries a nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_DZRO)
      else $error("undefined status code");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response one cycle after request");

endmodule

bind float_fdg_arith_unit fdg_checker u_fdg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_result_value (rsp_chan.result_value),
   .rsp_status       (rsp_chan.status)
);
